// File: hdl/sssa_pkg.sv
// Package for the strip sample slope angle core.
// Holds widths, slope coefficients, the CORDIC step table and shared types; no dependencies.
package sssa_pkg;

  localparam int SAMPLE_BITS     = 8;
  localparam int ANGLE_FRAC_BITS = 14;
  localparam int NUM_SAMPLES     = 6;
  localparam int OUT_BITS        = ANGLE_FRAC_BITS + 2;
  localparam int ZQ              = 30;
  localparam int CORDIC_ITERS    = 30;
  // |N| is at most 27 * max sample.
  localparam int NUM_MAG_BITS    = SAMPLE_BITS + 6;
  localparam int NUM_BITS        = NUM_MAG_BITS + 1;
  // X grows to about 1.65 * sqrt(105^2 + N^2) * 2^30.
  localparam int XY_BITS         = NUM_MAG_BITS + ZQ + 3;
  localparam int Z_BITS          = ZQ + 3;
  localparam int SLOPE_DEN       = 105;
  localparam longint PI_HALF_Q30 = 64'd1686629713;
  localparam int ITER_BITS       = $clog2(CORDIC_ITERS);

  localparam logic signed [OUT_BITS-1:0] NEG_PI_HALF = OUT_BITS'(-((PI_HALF_Q30 +
      (64'sd1 <<< (ZQ - 1 - ANGLE_FRAC_BITS))) >>> (ZQ - ANGLE_FRAC_BITS)));

  typedef logic signed [XY_BITS-1:0] xy_t;
  typedef logic signed [Z_BITS-1:0]  z_t;

  // Per-lane result of the front end: signed slope product and the sample itself.
  typedef struct packed {
    logic signed [NUM_BITS-1:0] prod;
    logic [SAMPLE_BITS-1:0]     samp;
  } lane_t;

  // Sideband that travels with the CORDIC pipeline.
  typedef struct packed {
    logic valid;
    logic neg;
    logic zero;
    logic below;
  } side_t;

  function automatic logic signed [5:0] slope_coef(input int k);
    logic signed [5:0] c;
    c = 6'(6 * k - 15);
    return c;
  endfunction

  function automatic z_t step_angle(input int i);
    z_t a;
    unique case (i)
      0: a = Z_BITS'(843314857);
      1: a = Z_BITS'(497837829);
      2: a = Z_BITS'(263043837);
      3: a = Z_BITS'(133525159);
      4: a = Z_BITS'(67021687);
      5: a = Z_BITS'(33543516);
      6: a = Z_BITS'(16775851);
      7: a = Z_BITS'(8388437);
      8: a = Z_BITS'(4194283);
      9: a = Z_BITS'(2097149);
      default: a = Z_BITS'(64'sd1 <<< (ZQ - i));
    endcase
    return a;
  endfunction

endpackage

// File: hdl/sssa_lane.sv
// One sample lane: passes the sample through and forms its weighted slope product.
// Depends on sssa_pkg.
module sssa_lane (
  input  logic [sssa_pkg::SAMPLE_BITS-1:0]    samp,
  input  logic signed [5:0]                   coef,
  output sssa_pkg::lane_t                     lane
);
  always_comb begin
    lane.samp = samp;
    lane.prod = $signed({{(sssa_pkg::NUM_BITS-sssa_pkg::SAMPLE_BITS){1'b0}}, samp}) *
                sssa_pkg::NUM_BITS'(coef);
  end
endmodule

// File: hdl/sssa_merge.sv
// Merging stage: sums lane products, finds the largest sample and applies the cut test.
// Depends on sssa_pkg; registered outputs feed the CORDIC pipeline.
module sssa_merge (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_fire,
  input  sssa_pkg::lane_t [sssa_pkg::NUM_SAMPLES-1:0] lanes,
  input  logic [15:0]                           strip_noise,
  input  logic [15:0]                           snr_cut,
  output sssa_pkg::side_t                       side_r,
  output logic [sssa_pkg::NUM_MAG_BITS-1:0]     mag_r
);
  logic signed [sssa_pkg::NUM_BITS-1:0] sum;
  logic [sssa_pkg::SAMPLE_BITS-1:0]     maxs;
  logic [31:0]                          cutprod;
  sssa_pkg::side_t                      side_nxt;
  logic [sssa_pkg::NUM_MAG_BITS-1:0]    mag_nxt;

  always_comb begin
    sum  = '0;
    maxs = '0;
    for (int k = 0; k < sssa_pkg::NUM_SAMPLES; k++) begin
      sum = sum + lanes[k].prod;
      if (lanes[k].samp > maxs) maxs = lanes[k].samp;
    end
    cutprod        = snr_cut * strip_noise;
    side_nxt.valid = in_fire;
    side_nxt.below = {16'd0, maxs, 16'd0} < {{(sssa_pkg::SAMPLE_BITS){1'b0}}, cutprod};
    side_nxt.neg   = sum[sssa_pkg::NUM_BITS-1];
    side_nxt.zero  = (sum == '0);
    mag_nxt        = sssa_pkg::NUM_MAG_BITS'(sum[sssa_pkg::NUM_BITS-1] ? -sum : sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else if (en) begin
      side_r <= side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) mag_r <= mag_nxt;
  end
endmodule

// File: hdl/sssa_cordic.sv
// Pipelined vectoring CORDIC, one micro-rotation per stage, with final rounding.
// Depends on sssa_pkg.
module sssa_cordic (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  sssa_pkg::side_t                       side_in,
  input  logic [sssa_pkg::NUM_MAG_BITS-1:0]     mag_in,
  output sssa_pkg::side_t                       side_out,
  output logic signed [sssa_pkg::OUT_BITS-1:0]  angle_out
);
  localparam int N = sssa_pkg::CORDIC_ITERS;
  localparam int SH = sssa_pkg::ZQ - sssa_pkg::ANGLE_FRAC_BITS;

  sssa_pkg::xy_t   x_r [N+1];
  sssa_pkg::xy_t   y_r [N+1];
  sssa_pkg::z_t    z_r [N+1];
  sssa_pkg::side_t s_r [N+1];

  always_comb begin
    x_r[0] = sssa_pkg::xy_t'(sssa_pkg::SLOPE_DEN) <<< sssa_pkg::ZQ;
    y_r[0] = sssa_pkg::xy_t'({1'b0, mag_in}) <<< sssa_pkg::ZQ;
    z_r[0] = '0;
    s_r[0] = side_in;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    sssa_pkg::xy_t x_nxt, y_nxt;
    sssa_pkg::z_t  z_nxt;
    always_comb begin
      // Arithmetic shift is a floor shift on two's complement values.
      if (!y_r[i][sssa_pkg::XY_BITS-1]) begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        z_nxt = z_r[i] + sssa_pkg::step_angle(i);
      end else begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        z_nxt = z_r[i] - sssa_pkg::step_angle(i);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_r[i+1] <= '0;
      end else if (en) begin
        s_r[i+1] <= s_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1] <= x_nxt;
        y_r[i+1] <= y_nxt;
        z_r[i+1] <= z_nxt;
      end
    end
  end

  sssa_pkg::z_t zc, zr;
  logic signed [sssa_pkg::OUT_BITS-1:0] mag_ang;
  always_comb begin
    zc = z_r[N][sssa_pkg::Z_BITS-1] ? '0 : z_r[N];
    zr = (zc + (sssa_pkg::z_t'(1) <<< (SH - 1))) >>> SH;
    mag_ang = sssa_pkg::OUT_BITS'(zr);
    side_out = s_r[N];
    if (s_r[N].below)      angle_out = sssa_pkg::NEG_PI_HALF;
    else if (s_r[N].zero)  angle_out = '0;
    else if (s_r[N].neg)   angle_out = -mag_ang;
    else                   angle_out = mag_ang;
  end
endmodule

// File: hdl/strip_sample_slope_angle_core.sv
// Top level of the strip sample slope angle core.
// Depends on sssa_pkg, sssa_lane, sssa_merge and sssa_cordic.
// One transaction is accepted per cycle while the pipeline is not stalled; each accepted
// transaction is loaded into the merging register, then passes through thirty CORDIC
// stages and an output register. Six lanes weigh the samples in parallel, the
// merging stage sums them and runs the noise cut, and the pipeline stalls as a whole
// when the output register is full and not taken.
module strip_sample_slope_angle_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [sssa_pkg::SAMPLE_BITS-1:0]       in_sample_0,
  input  logic [sssa_pkg::SAMPLE_BITS-1:0]       in_sample_1,
  input  logic [sssa_pkg::SAMPLE_BITS-1:0]       in_sample_2,
  input  logic [sssa_pkg::SAMPLE_BITS-1:0]       in_sample_3,
  input  logic [sssa_pkg::SAMPLE_BITS-1:0]       in_sample_4,
  input  logic [sssa_pkg::SAMPLE_BITS-1:0]       in_sample_5,
  input  logic [15:0]                            in_strip_noise,
  input  logic [15:0]                            in_snr_cut,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [sssa_pkg::OUT_BITS-1:0]   out_slope_angle,
  output logic                                   out_below_cut
);
  logic [sssa_pkg::SAMPLE_BITS-1:0] samps [sssa_pkg::NUM_SAMPLES];
  sssa_pkg::lane_t [sssa_pkg::NUM_SAMPLES-1:0] lanes;
  sssa_pkg::side_t side_m, side_c;
  logic [sssa_pkg::NUM_MAG_BITS-1:0] mag_m;
  logic signed [sssa_pkg::OUT_BITS-1:0] angle_c;
  logic en;
  logic out_valid_r;
  logic signed [sssa_pkg::OUT_BITS-1:0] angle_r;
  logic below_r;

  assign samps[0] = in_sample_0;
  assign samps[1] = in_sample_1;
  assign samps[2] = in_sample_2;
  assign samps[3] = in_sample_3;
  assign samps[4] = in_sample_4;
  assign samps[5] = in_sample_5;

  // The whole pipeline advances whenever the output register can take a new value.
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en && rst_n;

  for (genvar k = 0; k < sssa_pkg::NUM_SAMPLES; k++) begin : g_lane
    sssa_lane u_lane (
      .samp (samps[k]),
      .coef (sssa_pkg::slope_coef(k)),
      .lane (lanes[k])
    );
  end

  sssa_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_fire     (in_valid),
    .lanes       (lanes),
    .strip_noise (in_strip_noise),
    .snr_cut     (in_snr_cut),
    .side_r      (side_m),
    .mag_r       (mag_m)
  );

  sssa_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .side_in   (side_m),
    .mag_in    (mag_m),
    .side_out  (side_c),
    .angle_out (angle_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= side_c.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_c;
      below_r <= side_c.below;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_slope_angle = angle_r;
  assign out_below_cut   = below_r;
endmodule

// File: dv/strip_sample_slope_angle_checker.sv
// Checker for the strip sample slope angle core: watches both channels, predicts
// each result from the accepted input transaction and compares. Depends on sssa_pkg.
`timescale 1ns / 1ps

module strip_sample_slope_angle_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic [sssa_pkg::SAMPLE_BITS-1:0]     in_sample_0,
  input  logic [sssa_pkg::SAMPLE_BITS-1:0]     in_sample_1,
  input  logic [sssa_pkg::SAMPLE_BITS-1:0]     in_sample_2,
  input  logic [sssa_pkg::SAMPLE_BITS-1:0]     in_sample_3,
  input  logic [sssa_pkg::SAMPLE_BITS-1:0]     in_sample_4,
  input  logic [sssa_pkg::SAMPLE_BITS-1:0]     in_sample_5,
  input  logic [15:0]                          in_strip_noise,
  input  logic [15:0]                          in_snr_cut,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [sssa_pkg::OUT_BITS-1:0] out_slope_angle,
  input  logic                                 out_below_cut,
  output int                                   fail_count,
  output int                                   pending,
  output int                                   n_results,
  output int                                   n_below
);
  typedef struct packed {
    logic signed [sssa_pkg::OUT_BITS-1:0] angle;
    logic                                 below;
  } angle_res_t;

  angle_res_t expected_angles[$];

  // Floor shift on a signed value, same as an arithmetic right shift.
  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_step(int i);
    longint tbl[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                        33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return tbl[i];
    return longint'(1) <<< (sssa_pkg::ZQ - i);
  endfunction

  // Vectoring CORDIC for atan(mag/105), rounded to the output fraction.
  function automatic longint atan_of_mag(longint mag);
    longint x, y, z, xs, ys;
    x = longint'(105) <<< sssa_pkg::ZQ;
    y = mag <<< sssa_pkg::ZQ;
    z = 0;
    for (int i = 0; i < sssa_pkg::CORDIC_ITERS; i++) begin
      xs = fshr(x, i);
      ys = fshr(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + atan_step(i);
      end else begin
        x = x - ys; y = y + xs; z = z - atan_step(i);
      end
    end
    if (z < 0) z = 0;
    return (z + (longint'(1) <<< (sssa_pkg::ZQ - 1 - sssa_pkg::ANGLE_FRAC_BITS)))
           >>> (sssa_pkg::ZQ - sssa_pkg::ANGLE_FRAC_BITS);
  endfunction

  function automatic angle_res_t predict_angle(longint s[6], longint noise, longint cut);
    angle_res_t r;
    longint mx, num, a;
    mx = 0;
    num = 0;
    for (int k = 0; k < 6; k++) begin
      if (s[k] > mx) mx = s[k];
      num += (6 * k - 15) * s[k];
    end
    if ((mx <<< 16) < cut * noise) begin
      a = -((64'd1686629713 + (longint'(1) <<< (sssa_pkg::ZQ - 1 - sssa_pkg::ANGLE_FRAC_BITS)))
            >>> (sssa_pkg::ZQ - sssa_pkg::ANGLE_FRAC_BITS));
      r.below = 1'b1;
    end else begin
      if (num == 0) a = 0;
      else if (num > 0) a = atan_of_mag(num);
      else a = -atan_of_mag(-num);
      r.below = 1'b0;
    end
    r.angle = sssa_pkg::OUT_BITS'(a);
    return r;
  endfunction

  assign pending = expected_angles.size();

  initial begin
    fail_count = 0;
    n_results = 0;
    n_below = 0;
  end

  always @(posedge clk) begin
    longint s[6];
    angle_res_t exp_r;
    if (rst_n && in_valid && in_ready) begin
      s = '{in_sample_0, in_sample_1, in_sample_2, in_sample_3, in_sample_4, in_sample_5};
      expected_angles.push_back(predict_angle(s, in_strip_noise, in_snr_cut));
    end
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (out_below_cut) n_below++;
      if (expected_angles.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected result angle=%0d below=%0b", $realtime,
                   out_slope_angle, out_below_cut);
      end else begin
        exp_r = expected_angles.pop_front();
        if (exp_r.angle !== out_slope_angle || exp_r.below !== out_below_cut) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: mismatch angle exp=%0d got=%0d below exp=%0b got=%0b",
                     $realtime, exp_r.angle, out_slope_angle, exp_r.below, out_below_cut);
        end
      end
    end
  end
endmodule

// File: dv/strip_sample_slope_angle_core_tb.sv
// Testbench top for the strip sample slope angle core: drives bursts of digits,
// stalls the result side and gives the verdict. Depends on sssa_pkg and the checker.
`timescale 1ns / 1ps

module strip_sample_slope_angle_core_tb;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [sssa_pkg::SAMPLE_BITS-1:0] in_sample_0 = '0, in_sample_1 = '0, in_sample_2 = '0;
  logic [sssa_pkg::SAMPLE_BITS-1:0] in_sample_3 = '0, in_sample_4 = '0, in_sample_5 = '0;
  logic [15:0] in_strip_noise = '0, in_snr_cut = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [sssa_pkg::OUT_BITS-1:0] out_slope_angle;
  logic out_below_cut;
  int fail_count, pending, n_results, n_below;
  int n_sent = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  strip_sample_slope_angle_core u_dut (.*);
  strip_sample_slope_angle_checker u_chk (.*);

  // Receiver stall pattern: alternates free-running stretches with random stalls.
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(5, 60)) begin
        @(posedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_digit(input logic [7:0] s0, s1, s2, s3, s4, s5,
                            input logic [15:0] noise, cut);
    in_valid <= 1'b1;
    in_sample_0 <= s0; in_sample_1 <= s1; in_sample_2 <= s2;
    in_sample_3 <= s3; in_sample_4 <= s4; in_sample_5 <= s5;
    in_strip_noise <= noise;
    in_snr_cut <= cut;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  task automatic send_random_digit();
    logic [7:0] s[6];
    logic [15:0] noise, cut;
    int shape;
    shape = $urandom_range(0, 9);
    for (int k = 0; k < 6; k++) begin
      case (shape)
        0: s[k] = $urandom_range(0, 255);
        1: s[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        2: s[k] = $urandom_range(0, 8);
        default: s[k] = 8'(20 * k + $urandom_range(0, 60));
      endcase
    end
    // Pulse shapes: rising or falling trains.
    if (shape >= 7) s = '{s[5], s[4], s[3], s[2], s[1], s[0]};
    noise = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 16'h0800));
    cut = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 16'h0600));
    send_digit(s[0], s[1], s[2], s[3], s[4], s[5], noise, cut);
  endtask

  initial begin
    int tmo;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed digits: extremes, flat trains, the cut boundary and zero noise.
    send_digit(0, 0, 0, 0, 0, 0, 0, 0);
    send_digit(255, 255, 255, 255, 255, 255, 16'hFFFF, 16'hFFFF);
    send_digit(255, 255, 255, 255, 255, 255, 16'h0100, 16'h0300);
    send_digit(0, 0, 0, 0, 0, 255, 16'h0100, 16'h0300);
    send_digit(255, 0, 0, 0, 0, 0, 16'h0100, 16'h0300);
    send_digit(0, 0, 0, 0, 0, 255, 0, 16'hFFFF);
    send_digit(255, 0, 0, 0, 0, 255, 16'h0100, 16'h0100);
    send_digit(0, 255, 0, 0, 255, 0, 16'h0100, 16'h0100);
    send_digit(3, 3, 3, 3, 3, 3, 16'h0100, 16'h0300);
    send_digit(2, 2, 2, 2, 2, 2, 16'h0100, 16'h0300);
    send_digit(0, 0, 0, 0, 0, 1, 16'h0001, 16'h0001);
    send_digit(1, 0, 0, 0, 0, 0, 16'h0000, 16'h0000);
    send_digit(255, 255, 255, 0, 0, 0, 16'h0200, 16'h0300);
    send_digit(0, 0, 0, 255, 255, 255, 16'h0200, 16'h0300);
    send_digit(10, 40, 90, 120, 100, 60, 16'h0280, 16'h0300);
    send_digit(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 16'h5555, 16'hAAAA);
    send_digit(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 16'hAAAA, 16'h5555);
    in_valid <= 1'b0;

    while (n_sent < 730) begin
      repeat ($urandom_range(1, 40)) begin
        send_random_digit();
      end
      in_valid <= 1'b0;
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b0;

    tmo = 0;
    while (pending != 0 && tmo < 100000) begin
      @(posedge clk);
      tmo++;
    end
    repeat (40) @(posedge clk);
    $display("Sent %0d digits, checked %0d results, %0d below the noise cut.",
             n_sent, n_results, n_below);
    if (fail_count == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding.", pending);
    $display("*** FAILED ***");
    $finish;
  end
endmodule
